### rtl/ettg_pkg.sv
// ettg_pkg: shared types, constants and the quarter-wave sine table
// for the event timeline tone generator; no dependencies
`default_nettype none

package ettg_pkg;

	localparam int EVENT_DEPTH     = 256;
	localparam int SINE_TABLE_BITS = 10;
	localparam int MAX_RUN         = 64;

	localparam int ADDR_W  = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
	localparam int CNT_W   = $clog2(EVENT_DEPTH + 1);
	localparam int QBITS   = SINE_TABLE_BITS - 2;
	localparam int QUARTER_SIZE = 1 << QBITS;
	localparam int RUN_W   = 7;

	localparam logic [31:0] HZ_TO_STEP_RESET = 32'd89478;
	localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;

	// item kinds
	localparam logic [1:0] KIND_RESTART = 2'd0;
	localparam logic [1:0] KIND_APPEND  = 2'd1;
	localparam logic [1:0] KIND_RENDER  = 2'd2;

	typedef struct packed {
		logic [31:0] start_frame;
		logic [31:0] end_frame;
		logic [18:0] tone_freq;
		logic [15:0] tone_volume;
	} event_t;

	localparam int EVENT_W = $bits(event_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef logic [14:0] qtab_t [QUARTER_SIZE];

	// taylor divisors (2n)(2n+1) for n = 1..8
	localparam logic [63:0] TAYLOR_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// round(32767 * sin(pi/2 * k / quarter)) by integer series in q30
	function automatic logic [14:0] quarter_val(input int k);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		x = (HALF_PI_Q30 * 64'(k)) / QUARTER_SIZE;
		term = x;
		sum = x;
		for (int i = 0; i < 8; i++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / TAYLOR_DIV[i];
			if ((i & 1) == 0)
				sum = (sum >= term) ? sum - term : 64'd0;
			else
				sum = sum + term;
		end
		v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
		return (v > 64'd32767) ? 15'h7fff : v[14:0];
	endfunction

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int k = 0; k < QUARTER_SIZE; k++) begin
			t[k] = quarter_val(k);
		end
		return t;
	endfunction

	localparam qtab_t       QTAB         = build_qtab();
	localparam logic [14:0] QUARTER_PEAK = quarter_val(QUARTER_SIZE);

endpackage

`default_nettype wire

### rtl/ettg_ram.sv
// ettg_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ettg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/event_timeline_tone_generator_core.sv
// event_timeline_tone_generator_core: tone event table with a sine nco renderer
// depends on ettg_pkg and ettg_ram
//
// channel   signals                                                  handshake
// command   kind start_frame end_frame tone_freq tone_volume         start & !busy
//           run_length
// config    cfg_data                                                 cfg_we
// result    sample last_of_run status total_frames                   result_valid pulse
//
// restart, append and unused kinds keep busy low; their result shows the next cycle.
// a render first fetches the current event, then handles each sample in an event check,
// a multiply and an output step, and goes back to a fetch for every ended event the
// cursor steps over; each step is one read of the event ram.
// reset clears the counters, the cursor, the phase and the largest end frame; the event
// ram is not cleared, only entries below the event count are ever used.
// the receiver cannot stall: each result is on the ports for exactly one cycle.
`default_nettype none

module event_timeline_tone_generator_core
	import ettg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         kind,
	input  wire logic [31:0]        start_frame,
	input  wire logic [31:0]        end_frame,
	input  wire logic [18:0]        tone_freq,
	input  wire logic [15:0]        tone_volume,
	input  wire logic [6:0]         run_length,
	input  wire logic               cfg_we,
	input  wire logic [31:0]        cfg_data,
	output logic                    result_valid,
	output logic signed [15:0]      sample,
	output logic                    last_of_run,
	output logic                    status,
	output logic [31:0]             total_frames
);

	state_t state_q, state_next;

	logic [31:0]      hz_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cursor_q;
	logic [31:0]      frames_q;
	logic [31:0]      phase_q;
	logic [31:0]      max_end_q;
	logic [RUN_W-1:0] rem_q;
	logic             valid_q;

	logic signed [15:0] sample_q;
	logic               last_q;
	logic               status_q;
	logic [31:0]        total_q;

	// sample pipeline
	logic [14:0] mag_s1;
	logic        neg_s1;
	logic [15:0] vol_s1;
	logic [18:0] freq_s1;
	logic        active_s1;
	logic [30:0] prod_s2;
	logic [31:0] step_s2;
	logic        neg_s2;
	logic        active_s2;

	event_t rd_evt;
	event_t wr_evt;

	logic             accept;
	logic             room;
	logic [RUN_W-1:0] run_n;
	logic             have_evt;
	logic             skip;
	logic             in_evt;
	logic             ram_we;

	logic [SINE_TABLE_BITS-1:0] sidx;
	logic [1:0]                 quad;
	logic [QBITS-1:0]           jj;
	logic [QBITS-1:0]           jj_mir;
	logic [14:0]                smag;

	logic [50:0] step_full;
	logic [31:0] rounded;
	logic [16:0] rmag;
	logic signed [15:0] samp_calc;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);
	assign room   = (count_q < CNT_W'(EVENT_DEPTH));
	assign run_n  = (run_length > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : run_length;

	assign wr_evt = '{start_frame: start_frame, end_frame: end_frame,
		tone_freq: tone_freq, tone_volume: tone_volume};

	ettg_ram #(
		.WIDTH(EVENT_W),
		.DEPTH(EVENT_DEPTH)
	) u_evt_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(wr_evt),
		.raddr(cursor_q[ADDR_W-1:0]),
		.rdata(rd_evt)
	);

	assign have_evt = (cursor_q < count_q);
	assign skip     = have_evt && (frames_q >= rd_evt.end_frame);
	assign in_evt   = have_evt && (frames_q >= rd_evt.start_frame);

	// quarter-wave lookup of the phase
	assign sidx   = phase_q[31 -: SINE_TABLE_BITS];
	assign quad   = sidx[SINE_TABLE_BITS-1 -: 2];
	assign jj     = sidx[QBITS-1:0];
	assign jj_mir = QBITS'(0) - jj;

	always_comb begin
		if (!quad[0])
			smag = QTAB[jj];
		else if (jj == '0)
			smag = QUARTER_PEAK;
		else
			smag = QTAB[jj_mir];
	end

	assign step_full = 51'(freq_s1) * 51'(hz_q);

	// round, restore sign and saturate
	assign rounded = {1'b0, prod_s2} + 32'd16384;
	assign rmag    = rounded[31:15];

	always_comb begin
		if (!active_s2)
			samp_calc = '0;
		else if (neg_s2)
			samp_calc = (rmag > 17'd32768) ? 16'sh8000 : 16'(17'd0 - rmag);
		else
			samp_calc = (rmag > 17'd32767) ? 16'sh7fff : 16'(rmag);
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_RENDER && run_n != '0)
					state_next = ST_READ;
			end
			ST_READ:  state_next = ST_CHECK;
			ST_CHECK: state_next = skip ? ST_READ : ST_MUL;
			ST_MUL:   state_next = ST_OUT;
			ST_OUT:   state_next = (rem_q == RUN_W'(1)) ? ST_IDLE : ST_CHECK;
			default:  state_next = ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		ram_we = 1'b0;
		case (state_q)
			ST_IDLE: ram_we = accept && (kind == KIND_APPEND) && room;
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			hz_q      <= HZ_TO_STEP_RESET;
			count_q   <= '0;
			cursor_q  <= '0;
			frames_q  <= '0;
			phase_q   <= '0;
			max_end_q <= '0;
			rem_q     <= '0;
			valid_q   <= 1'b0;
		end else begin
			state_q <= state_next;
			valid_q <= (accept && kind != KIND_RENDER) || (state_q == ST_OUT);
			if (cfg_we)
				hz_q <= cfg_data;
			if (accept) begin
				case (kind)
					KIND_RESTART: begin
						count_q   <= '0;
						cursor_q  <= '0;
						frames_q  <= '0;
						phase_q   <= '0;
						max_end_q <= '0;
					end
					KIND_APPEND: begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
							if (end_frame > max_end_q)
								max_end_q <= end_frame;
						end
					end
					KIND_RENDER: rem_q <= run_n;
					default: ;
				endcase
			end
			if (state_q == ST_CHECK && skip)
				cursor_q <= cursor_q + CNT_W'(1);
			if (state_q == ST_OUT) begin
				rem_q <= rem_q - RUN_W'(1);
				if (frames_q != 32'hffff_ffff)
					frames_q <= frames_q + 32'd1;
				if (active_s2)
					phase_q <= phase_q + step_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && kind != KIND_RENDER) begin
			sample_q <= '0;
			last_q   <= 1'b1;
			status_q <= (kind == KIND_APPEND) && !room;
			if (kind == KIND_RESTART)
				total_q <= '0;
			else if (kind == KIND_APPEND && room && end_frame > max_end_q)
				total_q <= end_frame;
			else
				total_q <= max_end_q;
		end
		if (state_q == ST_CHECK) begin
			mag_s1    <= smag;
			neg_s1    <= quad[1];
			vol_s1    <= rd_evt.tone_volume;
			freq_s1   <= rd_evt.tone_freq;
			active_s1 <= in_evt;
		end
		if (state_q == ST_MUL) begin
			prod_s2   <= 31'(mag_s1) * 31'(vol_s1);
			step_s2   <= step_full[35:4];
			neg_s2    <= neg_s1;
			active_s2 <= active_s1;
		end
		if (state_q == ST_OUT) begin
			sample_q <= samp_calc;
			last_q   <= (rem_q == RUN_W'(1));
			status_q <= 1'b0;
			total_q  <= max_end_q;
		end
	end

	assign result_valid = valid_q;
	assign sample       = sample_q;
	assign last_of_run  = last_q;
	assign status       = status_q;
	assign total_frames = total_q;

	// the cursor never passes the end of the table
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= count_q)
		else $error("play cursor beyond event count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(EVENT_DEPTH))
		else $error("event count beyond table depth");

	// the final sample of a run returns the controller to idle
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && rem_q == RUN_W'(1)) |=> (state_q == ST_IDLE))
		else $error("render did not end after its last sample");

	// a result that is not the last of its transaction means more work is pending
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_of_run) |-> busy)
		else $error("intermediate result while idle");

endmodule

`default_nettype wire

### test/testbench.sv
// testbench: self-checking bench for event_timeline_tone_generator_core
// predicts every result of the event table and sine renderer itself; needs ettg_pkg and the rtl
`default_nettype none

module testbench;
	import ettg_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_PRINTS = 40;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] t_start;
		logic [31:0] t_end;
		logic [18:0] freq;
		logic [15:0] vol;
		logic [6:0]  run;
	} tone_cmd_t;

	typedef struct {
		logic signed [15:0] level;
		logic               last;
		logic               dropped;
		logic [31:0]        total;
	} tone_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         kind;
	logic [31:0]        start_frame;
	logic [31:0]        end_frame;
	logic [18:0]        tone_freq;
	logic [15:0]        tone_volume;
	logic [6:0]         run_length;
	logic               cfg_we;
	logic [31:0]        cfg_data;
	logic               result_valid;
	logic signed [15:0] sample;
	logic               last_of_run;
	logic               status;
	logic [31:0]        total_frames;

	// predictor state
	logic [31:0] ev_start [EVENT_DEPTH];
	logic [31:0] ev_end [EVENT_DEPTH];
	logic [18:0] ev_freq [EVENT_DEPTH];
	logic [15:0] ev_vol [EVENT_DEPTH];
	int          ev_count;
	int          play_pos;
	logic [31:0] frame_cnt;
	logic [31:0] phase;
	logic [31:0] max_end_seen;
	logic [31:0] hz_step;
	int          quarter_wave [QUARTER_SIZE + 1];

	tone_result_t tone_results_due [$];
	int mismatches;
	int results_seen;
	int items_sent;
	int idle_pct;
	int stall_cycles;

	event_timeline_tone_generator_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.start_frame  (start_frame),
		.end_frame    (end_frame),
		.tone_freq    (tone_freq),
		.tone_volume  (tone_volume),
		.run_length   (run_length),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.sample       (sample),
		.last_of_run  (last_of_run),
		.status       (status),
		.total_frames (total_frames)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// quarter-wave table: taylor series of sin in q30, rounded to 15 bits
	initial begin : sine_rom
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		for (int k = 0; k <= QUARTER_SIZE; k++) begin
			x = (HALF_PI_Q30 * 64'(k)) / QUARTER_SIZE;
			term = x;
			sum = x;
			for (int n = 1; n <= 8; n++) begin
				term = (((term * x) >> 30) * x) >> 30;
				term = term / (64'(2 * n) * 64'(2 * n + 1));
				if (n % 2 == 1)
					sum = (sum >= term) ? sum - term : 64'd0;
				else
					sum = sum + term;
			end
			v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
			quarter_wave[k] = (v > 64'd32767) ? 32767 : int'(v);
		end
	end

	function automatic tone_cmd_t make_cmd(input logic [1:0] op, input logic [31:0] s,
			input logic [31:0] e, input logic [18:0] f, input logic [15:0] v,
			input logic [6:0] r);
		tone_cmd_t c;
		c.op = op;
		c.t_start = s;
		c.t_end = e;
		c.freq = f;
		c.vol = v;
		c.run = r;
		return c;
	endfunction

	// one frame of the renderer: cursor skip, sine lookup, volume scaling, phase advance
	function automatic logic signed [15:0] render_next_sample();
		logic signed [15:0] level;
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [1:0] quad;
		logic [63:0] prod;
		int j;
		int mag;
		longint m;
		longint r;
		level = '0;
		while (play_pos < ev_count && frame_cnt >= ev_end[play_pos])
			play_pos++;
		if (play_pos < ev_count && frame_cnt >= ev_start[play_pos]) begin
			idx = phase[31 -: SINE_TABLE_BITS];
			quad = idx[SINE_TABLE_BITS-1 -: 2];
			j = int'(idx[QBITS-1:0]);
			mag = quad[0] ? quarter_wave[QUARTER_SIZE - j] : quarter_wave[j];
			m = (longint'(mag) * longint'({48'd0, ev_vol[play_pos]}) + 64'sd16384) >>> 15;
			r = quad[1] ? -m : m;
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			level = r[15:0];
			prod = 64'(ev_freq[play_pos]) * 64'(hz_step);
			phase = phase + prod[35:4];
		end
		if (frame_cnt != 32'hffff_ffff)
			frame_cnt++;
		return level;
	endfunction

	function automatic void predict_tone_results(input tone_cmd_t c);
		tone_result_t r;
		int n;
		r.level = '0;
		r.last = 1'b1;
		r.dropped = 1'b0;
		case (c.op)
			KIND_RENDER: begin
				n = (c.run > MAX_RUN) ? MAX_RUN : int'(c.run);
				for (int i = 0; i < n; i++) begin
					r.level = render_next_sample();
					r.last = (i == n - 1);
					r.total = max_end_seen;
					tone_results_due.push_back(r);
				end
				return;
			end
			KIND_RESTART: begin
				ev_count = 0;
				play_pos = 0;
				frame_cnt = '0;
				phase = '0;
				max_end_seen = '0;
			end
			KIND_APPEND: begin
				if (ev_count < EVENT_DEPTH) begin
					ev_start[ev_count] = c.t_start;
					ev_end[ev_count] = c.t_end;
					ev_freq[ev_count] = c.freq;
					ev_vol[ev_count] = c.vol;
					ev_count++;
					if (c.t_end > max_end_seen)
						max_end_seen = c.t_end;
				end else begin
					r.dropped = 1'b1;
				end
			end
			default: ;
		endcase
		r.total = max_end_seen;
		tone_results_due.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want_v);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch on %s: got %0h, want %0h (result %0d)", what, got, want_v,
				results_seen);
	endtask

	// results are sampled mid-cycle, away from the clock edge
	always @(negedge clk) begin : result_check
		tone_result_t want;
		if (arst_n && result_valid) begin
			if (tone_results_due.size() == 0) begin
				report_mismatch("transaction with none pending", 32'(sample), 32'd0);
			end else begin
				want = tone_results_due.pop_front();
				if (sample !== want.level)
					report_mismatch("sample", 32'(sample), 32'(want.level));
				if (last_of_run !== want.last)
					report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
				if (status !== want.dropped)
					report_mismatch("status", 32'(status), 32'(want.dropped));
				if (total_frames !== want.total)
					report_mismatch("total_frames", total_frames, want.total);
			end
			results_seen++;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (result_valid || (start && !busy))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send_tone(input tone_cmd_t c);
		bit taken;
		kind <= c.op;
		start_frame <= c.t_start;
		end_frame <= c.t_end;
		tone_freq <= c.freq;
		tone_volume <= c.vol;
		run_length <= c.run;
		start <= 1'b1;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		predict_tone_results(c);
		items_sent++;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (tone_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_step_reg(input logic [31:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		hz_step = v;
		cfg_we <= 1'b0;
	endtask

	// an optional restart, a few sorted events near the current frame, then renders across them
	task automatic play_sequence();
		int n;
		int k;
		logic [31:0] tail;
		logic [31:0] s;
		logic [31:0] e;
		logic [15:0] v;
		n = $urandom_range(1, 6);
		if ($urandom_range(0, 1) == 0 || ev_count + n > EVENT_DEPTH ||
				max_end_seen > 32'hf000_0000 || frame_cnt > 32'hf000_0000)
			send_tone(make_cmd(KIND_RESTART, $urandom, $urandom, 19'($urandom),
				16'($urandom), 7'($urandom)));
		tail = (max_end_seen > frame_cnt) ? max_end_seen : frame_cnt;
		repeat (n) begin
			s = tail + $urandom_range(0, 12);
			e = s + (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 48));
			v = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
			send_tone(make_cmd(KIND_APPEND, s, e, 19'($urandom_range(0, 524287)), v,
				7'($urandom)));
			tail = e;
		end
		k = 0;
		while (frame_cnt <= tail && k < 8) begin
			send_tone(make_cmd(KIND_RENDER, $urandom, $urandom, 19'($urandom),
				16'($urandom), 7'($urandom_range(1, MAX_RUN))));
			k++;
		end
		if ($urandom_range(0, 3) == 0)
			send_tone(make_cmd(KIND_RENDER, $urandom, $urandom, 19'($urandom),
				16'($urandom), 7'($urandom_range(1, 16))));
	endtask

	task automatic test_directed();
		idle_pct = 0;
		send_tone(make_cmd(KIND_RESTART, '0, '0, '0, '0, '0));
		send_tone(make_cmd(KIND_UNUSED, '0, '0, '0, '0, '0));
		send_tone(make_cmd(KIND_APPEND, 32'd0, 32'd10, 19'h7ffff, 16'd32768, '0));
		send_tone(make_cmd(KIND_APPEND, 32'd12, 32'd20, 19'd7040, 16'hffff, '0));
		// zero duration and inverted interval are skipped by the cursor
		send_tone(make_cmd(KIND_APPEND, 32'd22, 32'd22, 19'd1000, 16'd100, '0));
		send_tone(make_cmd(KIND_APPEND, 32'd30, 32'd25, 19'd3000, 16'd16384, '0));
		send_tone(make_cmd(KIND_APPEND, 32'd40, 32'd70, 19'd12345, 16'd0, '0));
		send_tone(make_cmd(KIND_RENDER, '0, '0, '0, '0, 7'd0));
		send_tone(make_cmd(KIND_RENDER, '0, '0, '0, '0, 7'd1));
		send_tone(make_cmd(KIND_RENDER, '1, '1, '1, '1, 7'd64));
		send_tone(make_cmd(KIND_RENDER, '0, '0, '0, '0, 7'd127));
		send_tone(make_cmd(KIND_UNUSED, '1, '1, '1, '1, '1));
		send_tone(make_cmd(KIND_APPEND, 32'hffff_ffff, 32'hffff_ffff, 19'd0, 16'd0, '1));
		send_tone(make_cmd(KIND_RENDER, '0, '0, '0, '0, 7'd7));
		send_tone(make_cmd(KIND_RESTART, '1, '1, '1, '1, '1));
		send_tone(make_cmd(KIND_RENDER, '0, '0, '0, '0, 7'd5));
		send_tone(make_cmd(KIND_APPEND, 32'd0, 32'hffff_ffff, 19'h7ffff, 16'hffff, '0));
		send_tone(make_cmd(KIND_RENDER, '0, '0, '0, '0, 7'd64));
		send_tone(make_cmd(KIND_RENDER, '0, '0, '0, '0, 7'd65));
		drain_results();
	endtask

	task automatic test_step_register();
		logic [31:0] steps [4];
		steps[0] = 32'd0;
		steps[1] = 32'hffff_ffff;
		steps[2] = $urandom;
		steps[3] = HZ_TO_STEP_RESET;
		idle_pct = 0;
		foreach (steps[i]) begin
			write_step_reg(steps[i]);
			send_tone(make_cmd(KIND_RESTART, '0, '0, '0, '0, '0));
			send_tone(make_cmd(KIND_APPEND, 32'd0, 32'd30, 19'($urandom_range(0, 524287)),
				16'd32768, '0));
			send_tone(make_cmd(KIND_APPEND, 32'd30, 32'd60, 19'($urandom_range(0, 524287)),
				16'($urandom), '0));
			send_tone(make_cmd(KIND_RENDER, '0, '0, '0, '0, 7'd64));
		end
		drain_results();
	endtask

	// fill the table, push past it, and make the cursor step over many ended events at once
	task automatic test_table_overflow();
		logic [31:0] s;
		idle_pct = 34;
		send_tone(make_cmd(KIND_RESTART, '0, '0, '0, '0, '0));
		for (int i = 0; i < EVENT_DEPTH + 3; i++) begin
			if (i < EVENT_DEPTH / 2) begin
				s = '0;
				send_tone(make_cmd(KIND_APPEND, s, 32'd0, 19'($urandom), 16'($urandom), '0));
			end else begin
				s = 32'(2 * (i - EVENT_DEPTH / 2));
				send_tone(make_cmd(KIND_APPEND, s, s + $urandom_range(0, 3),
					19'($urandom_range(0, 524287)), 16'($urandom_range(0, 32768)), '0));
			end
		end
		repeat (5)
			send_tone(make_cmd(KIND_RENDER, '0, '0, '0, '0, 7'd64));
		send_tone(make_cmd(KIND_APPEND, 32'd1, 32'hffff_fff0, '1, '1, '0));
		send_tone(make_cmd(KIND_RENDER, '0, '0, '0, '0, 7'd3));
		drain_results();
	endtask

	task automatic test_random_phase(input int pct, input int item_goal);
		int first;
		idle_pct = pct;
		first = items_sent;
		while (items_sent - first < item_goal) begin
			if ($urandom_range(0, 9) < 8)
				play_sequence();
			else
				send_tone(make_cmd(2'($urandom_range(0, 3)), $urandom, $urandom,
					19'($urandom), 16'($urandom), 7'($urandom_range(0, 127))));
		end
		drain_results();
	endtask

	initial begin
		kind <= KIND_RESTART;
		start <= 1'b0;
		start_frame <= '0;
		end_frame <= '0;
		tone_freq <= '0;
		tone_volume <= '0;
		run_length <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		ev_count = 0;
		play_pos = 0;
		frame_cnt = '0;
		phase = '0;
		max_end_seen = '0;
		hz_step = HZ_TO_STEP_RESET;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		idle_pct = 0;
		stall_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_step_register();
		test_table_overflow();
		test_random_phase(0, 4);
		write_step_reg($urandom);
		test_random_phase(61, 4);
		write_step_reg(32'hffff_ffff);
		test_random_phase(34, 4);
		write_step_reg(HZ_TO_STEP_RESET);
		test_random_phase(0, 4);

		drain_results();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
